[rtl/cws_pkg.sv]
// ----------------------------------------------------------------------------
// cws_pkg
// Shared constants, job record and state type for the weighted sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cws_pkg;

  localparam int MAX_WEIGHTS = 1024;
  localparam int WEIGHT_BITS = 24;
  localparam int DRAW_BITS   = 32;

  // index into one bank, and a count that can also hold MAX_WEIGHTS itself
  localparam int IDX_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
  localparam int CNT_W = $clog2(MAX_WEIGHTS + 1);

  // cumulative sums never exceed MAX_WEIGHTS * (2^WEIGHT_BITS - 1)
  localparam int SUM_W = WEIGHT_BITS + IDX_W;

  // total as used by the split multiply: always at least one bit above DRAW_BITS
  localparam int TOT_W = (SUM_W > DRAW_BITS) ? SUM_W : DRAW_BITS + 1;
  localparam int THR_W = TOT_W + 1;

  // two banks of cumulative sums, one filling while the other is searched
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam int OUT_IDX_W = 10;

  localparam int S_DATA_W = ((WEIGHT_BITS + DRAW_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((OUT_IDX_W + 7) / 8) * 8;
  localparam int M_USER_W = 2;

  typedef struct packed {
    logic [DRAW_BITS-1:0] u;
    logic [SUM_W-1:0]     total;
    logic [CNT_W-1:0]     count;
    logic                 dropped;
  } cws_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_THR,
    BK_SCAN,
    BK_EMIT
  } cws_back_state_t;

endpackage

`default_nettype wire

[rtl/cws_ram.sv]
// ----------------------------------------------------------------------------
// cws_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/cws_front.sv]
// ----------------------------------------------------------------------------
// cws_front
// Takes one weight per cycle unless the queue is full, keeps the running total,
// writes each cumulative sum in the current bank; the last posts a draw job.
// ----------------------------------------------------------------------------
`default_nettype none

module cws_front
  import cws_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [WEIGHT_BITS-1:0] in_weight,
  input  wire logic [DRAW_BITS-1:0]   in_u,
  input  wire logic                   in_last,
  input  wire logic                   q_full,
  input  wire logic                   q_bank,
  output logic                        q_push,
  output cws_job_t                    q_job,
  output logic                        ram_we,
  output logic [RAM_AW-1:0]           ram_waddr,
  output logic [SUM_W-1:0]            ram_wdata
);

  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] total;
  logic             ovf;

  logic             accept;
  logic             room;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] count_next;
  logic [SUM_W-1:0] total_next;
  logic             ovf_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign room     = (count < CNT_W'(MAX_WEIGHTS));
  assign sum_add  = total + SUM_W'(in_weight);

  assign ram_we    = accept && room;
  assign ram_waddr = {q_bank, count[IDX_W-1:0]};
  assign ram_wdata = sum_add;

  always_comb begin
    count_next = count;
    total_next = total;
    ovf_next   = ovf;
    if (accept) begin
      if (room) begin
        count_next = count + CNT_W'(1);
        total_next = sum_add;
      end else begin
        ovf_next = 1'b1;
      end
    end
    q_push        = accept && in_last;
    q_job.u       = in_u;
    q_job.total   = total_next;
    q_job.count   = count_next;
    q_job.dropped = ovf_next;
    // start a fresh set after the draw item
    if (q_push) begin
      count_next = '0;
      total_next = '0;
      ovf_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      total <= total_next;
      ovf   <= ovf_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cws_queue.sv]
// ----------------------------------------------------------------------------
// cws_queue
// Two-entry job queue. An entry stays until its search is done, so the write
// pointer also names the bank that is free for filling.
// ----------------------------------------------------------------------------
`default_nettype none

module cws_queue
  import cws_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire cws_job_t push_job,
  input  wire logic     pop,
  output cws_job_t      head,
  output logic          head_bank,
  output logic          full,
  output logic          empty,
  output logic          wr_bank
);

  cws_job_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign empty     = (cnt == 2'd0);
  assign head      = slot[rd_ptr];
  assign head_bank = rd_ptr;
  assign wr_bank   = wr_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cws_back.sv]
// ----------------------------------------------------------------------------
// cws_back
// Runs one draw; for a nonzero total forms ceil(u * total / 2^32) with a split
// multiply, then scans the bank for the first cumulative sum that reaches it.
// ----------------------------------------------------------------------------
`default_nettype none

module cws_back
  import cws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cws_job_t            job,
  input  wire logic                job_bank,
  input  wire logic                job_empty,
  output logic                     job_pop,
  output logic                     ram_re,
  output logic [RAM_AW-1:0]        ram_raddr,
  input  wire logic [SUM_W-1:0]    ram_rdata,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_IDX_W-1:0]     out_index,
  output logic                     out_zero,
  output logic                     out_dropped
);

  cws_back_state_t state, state_next;

  logic [2*DRAW_BITS-1:0] p_lo, p_lo_next;
  logic [TOT_W-1:0]       p_hi, p_hi_next;
  logic [THR_W-1:0]       thr, thr_next;
  logic [IDX_W-1:0]       iss, iss_next;
  logic                   chk_vld, chk_vld_next;
  logic [IDX_W-1:0]       chk_idx, chk_idx_next;
  logic [IDX_W-1:0]       res_idx, res_idx_next;
  logic                   res_zero, res_zero_next;
  logic                   out_valid_next;
  logic [OUT_IDX_W-1:0]   out_index_next;
  logic                   out_zero_next;
  logic                   out_dropped_next;

  logic [TOT_W-1:0]       tot_ext;
  logic [IDX_W-1:0]       last_idx;
  logic                   hit;

  assign tot_ext  = TOT_W'(job.total);
  assign last_idx = IDX_W'(job.count - CNT_W'(1));
  // cum * 2^32 >= u * total  <=>  cum >= ceil(u * total / 2^32)
  assign hit      = (THR_W'(ram_rdata) >= thr);

  always_comb begin
    state_next       = state;
    p_lo_next        = p_lo;
    p_hi_next        = p_hi;
    thr_next         = thr;
    iss_next         = iss;
    chk_vld_next     = chk_vld;
    chk_idx_next     = chk_idx;
    res_idx_next     = res_idx;
    res_zero_next    = res_zero;
    out_valid_next   = out_valid && !out_ready;
    out_index_next   = out_index;
    out_zero_next    = out_zero;
    out_dropped_next = out_dropped;
    job_pop          = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = {job_bank, iss};

    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          if (job.total == '0) begin
            res_idx_next  = '0;
            res_zero_next = 1'b1;
            state_next    = BK_EMIT;
          end else begin
            res_zero_next = 1'b0;
            state_next    = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        p_lo_next  = job.u * tot_ext[DRAW_BITS-1:0];
        p_hi_next  = job.u * tot_ext[TOT_W-1:DRAW_BITS];
        state_next = BK_THR;
      end
      BK_THR: begin
        // round the high half up when any low bit is set
        thr_next     = THR_W'(p_hi) + THR_W'(p_lo[2*DRAW_BITS-1:DRAW_BITS])
                       + THR_W'(|p_lo[DRAW_BITS-1:0]);
        iss_next     = '0;
        chk_vld_next = 1'b0;
        state_next   = BK_SCAN;
      end
      BK_SCAN: begin
        // the last stored sum equals the total, so the scan ends there at the latest
        if (chk_vld && (hit || chk_idx == last_idx)) begin
          res_idx_next = chk_idx;
          state_next   = BK_EMIT;
        end else begin
          ram_re       = 1'b1;
          iss_next     = iss + IDX_W'(1);
          chk_vld_next = 1'b1;
          chk_idx_next = iss;
        end
      end
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          out_index_next   = OUT_IDX_W'(res_idx);
          out_zero_next    = res_zero;
          out_dropped_next = job.dropped;
          job_pop          = 1'b1;
          state_next       = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_vld   <= chk_vld_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p_lo        <= p_lo_next;
    p_hi        <= p_hi_next;
    thr         <= thr_next;
    iss         <= iss_next;
    chk_idx     <= chk_idx_next;
    res_idx     <= res_idx_next;
    res_zero    <= res_zero_next;
    out_index   <= out_index_next;
    out_zero    <= out_zero_next;
    out_dropped <= out_dropped_next;
  end

endmodule

`default_nettype wire

[rtl/categorical_weight_sampler.sv]
// Flow: one weight per cycle while s_tready; a draw then runs BK_IDLE, BK_MUL,
//   BK_THR, BK_SCAN (one stored sum read per cycle up to the chosen index) and
//   BK_EMIT (a zero total skips to BK_EMIT), plus any wait for an earlier draw
//   or the output to drain. The next set streams in while a draw is searched;
//   the input stalls only while two sets are queued.
// Reset: synchronous, active high; clears counts, totals, queue and output.
// ----------------------------------------------------------------------------
// categorical_weight_sampler
// Roulette wheel draw of one index from a stream of unsigned weights.
// ----------------------------------------------------------------------------
`default_nettype none

module categorical_weight_sampler
  import cws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // weight, uniform_draw
  input  wire logic                s_tlast,  // is_last
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,  // chosen_index, zero pad
  output logic [M_USER_W-1:0]      m_tuser   // zero_total, dropped
);

  logic              q_full;
  logic              q_empty;
  logic              q_wr_bank;
  logic              q_push;
  logic              q_pop;
  cws_job_t          q_in;
  cws_job_t          q_head;
  logic              q_head_bank;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [SUM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [SUM_W-1:0]  ram_rdata;

  logic [OUT_IDX_W-1:0] out_index;
  logic                 out_zero;
  logic                 out_dropped;

  cws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_weight (s_tdata[WEIGHT_BITS-1:0]),
    .in_u      (s_tdata[WEIGHT_BITS +: DRAW_BITS]),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .q_bank    (q_wr_bank),
    .q_push    (q_push),
    .q_job     (q_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  cws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .head_bank (q_head_bank),
    .full      (q_full),
    .empty     (q_empty),
    .wr_bank   (q_wr_bank)
  );

  cws_ram #(
    .WIDTH (SUM_W),
    .DEPTH (RAM_DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (q_head),
    .job_bank    (q_head_bank),
    .job_empty   (q_empty),
    .job_pop     (q_pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_index   (out_index),
    .out_zero    (out_zero),
    .out_dropped (out_dropped)
  );

  assign m_tdata = M_DATA_W'(out_index);
  assign m_tuser = {out_dropped, out_zero};

endmodule

`default_nettype wire
